// ===== rtl/sorted_priority_queue_core_defines.svh =====
// Assertion macros shared by the sorted priority queue RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

	localparam int unsigned SPQ_DEPTH          = 16;
	localparam int unsigned SPQ_VALUE_WIDTH    = 32;
	localparam int unsigned SPQ_PRIORITY_WIDTH = 16;

	// Command queue between front and back
	localparam int unsigned FQ_DEPTH = 2;
	localparam int unsigned FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int unsigned FQ_CNT_W = $clog2(FQ_DEPTH + 1);

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Control side of a queued command word
	typedef struct packed {
		logic valid;
		op_t  op;
	} cmd_ctl_t;

endpackage

// ===== rtl/spq_front.sv =====
// Front end: accepts input words, decodes the operation and buffers them in a
// short command queue ahead of the slot array. Depends on spq_pkg.
`include "sorted_priority_queue_core_defines.svh"
module spq_front #(
	parameter int unsigned VALUE_WIDTH    = spq_pkg::SPQ_VALUE_WIDTH,
	parameter int unsigned PRIORITY_WIDTH = spq_pkg::SPQ_PRIORITY_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic                             kind,
	input  logic [VALUE_WIDTH-1:0]           item_value,
	input  logic signed [PRIORITY_WIDTH-1:0] item_priority,
	output spq_pkg::cmd_ctl_t                cmd_ctl,
	output logic [VALUE_WIDTH-1:0]           cmd_value,
	output logic signed [PRIORITY_WIDTH-1:0] cmd_priority,
	input  logic                             cmd_stall
);
	import spq_pkg::*;

	op_t                             op_q  [FQ_DEPTH];
	logic [VALUE_WIDTH-1:0]          val_q [FQ_DEPTH];
	logic signed [PRIORITY_WIDTH-1:0] pri_q [FQ_DEPTH];
	logic [FQ_PTR_W-1:0]             wr_ptr_q;
	logic [FQ_PTR_W-1:0]             rd_ptr_q;
	logic [FQ_CNT_W-1:0]             cnt_q;
	logic                            push;
	logic                            pop;

	// Stall the sender while the queue is full
	assign item_stall = (cnt_q == FQ_CNT_W'(FQ_DEPTH));
	assign push       = item_valid && !item_stall;
	assign pop        = cmd_ctl.valid && !cmd_stall;

	// Present the oldest word to the back end
	assign cmd_ctl.valid = (cnt_q != '0);
	assign cmd_ctl.op    = op_q[rd_ptr_q];
	assign cmd_value     = val_q[rd_ptr_q];
	assign cmd_priority  = pri_q[rd_ptr_q];

	// Decode and store the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]  <= op_t'(kind);
			val_q[wr_ptr_q] <= item_value;
			pri_q[wr_ptr_q] <= item_priority;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SPQ_ASSERT_IMP(a_fq_bound, clk, arst_n, 1'b1, cnt_q <= FQ_CNT_W'(FQ_DEPTH), "command queue overfilled")
	`SPQ_ASSERT_NXT(a_fq_fill, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "push lost in command queue")
	`SPQ_ASSERT_IMP(a_fq_ptrs, clk, arst_n, cnt_q == '0, wr_ptr_q == rd_ptr_q, "empty queue with split pointers")

endmodule

// ===== rtl/spq_back.sv =====
// Back end: sorted slot array that inserts or removes one entry per cycle unless
// the held result stalls it, plus the result output register. Depends on spq_pkg.
`include "sorted_priority_queue_core_defines.svh"
module spq_back #(
	parameter int unsigned DEPTH          = spq_pkg::SPQ_DEPTH,
	parameter int unsigned VALUE_WIDTH    = spq_pkg::SPQ_VALUE_WIDTH,
	parameter int unsigned PRIORITY_WIDTH = spq_pkg::SPQ_PRIORITY_WIDTH,
	parameter int unsigned CNT_W          = $clog2(DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spq_pkg::cmd_ctl_t                cmd_ctl,
	input  logic [VALUE_WIDTH-1:0]           cmd_value,
	input  logic signed [PRIORITY_WIDTH-1:0] cmd_priority,
	output logic                             cmd_stall,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [1:0]                       status,
	output logic [VALUE_WIDTH-1:0]           out_value,
	output logic signed [PRIORITY_WIDTH-1:0] out_priority,
	output logic [CNT_W-1:0]                 occupancy
);
	import spq_pkg::*;

	// Slot 0 holds the entry that leaves next
	logic [VALUE_WIDTH-1:0]           val_q [DEPTH];
	logic signed [PRIORITY_WIDTH-1:0] pri_q [DEPTH];
	logic [VALUE_WIDTH-1:0]           val_d [DEPTH];
	logic signed [PRIORITY_WIDTH-1:0] pri_d [DEPTH];
	logic [DEPTH-1:0]                 ge;
	logic [CNT_W-1:0]                 count_q;
	logic [CNT_W-1:0]                 count_d;

	logic                             res_valid_q;
	status_t                          status_q;
	logic [VALUE_WIDTH-1:0]           out_value_q;
	logic signed [PRIORITY_WIDTH-1:0] out_pri_q;
	logic [CNT_W-1:0]                 occ_q;

	logic cmd_fire;
	logic full;
	logic empty;
	logic do_enq;
	logic do_deq;

	assign cmd_stall = res_valid_q && result_stall;
	assign cmd_fire  = cmd_ctl.valid && !cmd_stall;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_enq    = cmd_fire && (cmd_ctl.op == OP_ENQ) && !full;
	assign do_deq    = cmd_fire && (cmd_ctl.op == OP_DEQ) && !empty;

	// Per-slot insert or shift decision
	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		// Slot stays ahead of the new word when it is held and not lower
		assign ge[i] = (CNT_W'(i) < count_q) && (pri_q[i] >= cmd_priority);
		if (i == DEPTH - 1) begin : g_tail
			logic prev_ge;
			assign prev_ge = ge[i-1];
			always_comb begin
				if (do_deq) begin
					val_d[i] = val_q[i];
					pri_d[i] = pri_q[i];
				end else if (ge[i]) begin
					val_d[i] = val_q[i];
					pri_d[i] = pri_q[i];
				end else if (prev_ge) begin
					val_d[i] = cmd_value;
					pri_d[i] = cmd_priority;
				end else begin
					val_d[i] = val_q[i-1];
					pri_d[i] = pri_q[i-1];
				end
			end
		end else if (i == 0) begin : g_first
			always_comb begin
				if (do_deq) begin
					val_d[i] = val_q[i+1];
					pri_d[i] = pri_q[i+1];
				end else if (ge[i]) begin
					val_d[i] = val_q[i];
					pri_d[i] = pri_q[i];
				end else begin
					val_d[i] = cmd_value;
					pri_d[i] = cmd_priority;
				end
			end
		end else begin : g_mid
			logic prev_ge;
			assign prev_ge = ge[i-1];
			always_comb begin
				if (do_deq) begin
					val_d[i] = val_q[i+1];
					pri_d[i] = pri_q[i+1];
				end else if (ge[i]) begin
					val_d[i] = val_q[i];
					pri_d[i] = pri_q[i];
				end else if (prev_ge) begin
					val_d[i] = cmd_value;
					pri_d[i] = cmd_priority;
				end else begin
					val_d[i] = val_q[i-1];
					pri_d[i] = pri_q[i-1];
				end
			end
		end
	end

	// Update the slot array on a successful operation
	always_ff @(posedge clk) begin
		if (do_enq || do_deq) begin
			for (int i = 0; i < DEPTH; i++) begin
				val_q[i] <= val_d[i];
				pri_q[i] <= pri_d[i];
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (do_enq) begin
			count_d = count_q + 1'b1;
		end else if (do_deq) begin
			count_d = count_q - 1'b1;
		end
	end

	// Hold the entry count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd_fire) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			occ_q <= count_d;
			if (do_deq) begin
				status_q    <= ST_DONE;
				out_value_q <= val_q[0];
				out_pri_q   <= pri_q[0];
			end else begin
				out_value_q <= '0;
				out_pri_q   <= '0;
				if (do_enq) begin
					status_q <= ST_DONE;
				end else if (cmd_ctl.op == OP_DEQ) begin
					status_q <= ST_EMPTY;
				end else begin
					status_q <= ST_FULL;
				end
			end
		end
	end

	assign result_valid = res_valid_q;
	assign status       = status_q;
	assign out_value    = out_value_q;
	assign out_priority = out_pri_q;
	assign occupancy    = occ_q;

	`SPQ_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`SPQ_ASSERT_NXT(a_enq_count, clk, arst_n, do_enq, count_q == $past(count_q) + 1'b1, "insert did not grow the queue")
	`SPQ_ASSERT_IMP(a_full_occ, clk, arst_n, res_valid_q && (status_q == ST_FULL), occ_q == CNT_W'(DEPTH), "full status on a queue that is not full")
	`SPQ_ASSERT_IMP(a_sorted, clk, arst_n, count_q >= CNT_W'(2), pri_q[0] >= pri_q[1], "head slots out of order")

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Sorted priority queue, top level.
// Input channel (item_valid/item_stall): kind 0 enqueues item_value with the
// signed item_priority, kind 1 dequeues the highest-priority entry; equal
// priorities leave in arrival order.
// Output channel (result_valid/result_stall): one word per input word with
// status (done, dequeue on empty, enqueue on full), the removed value and
// priority (zero unless a dequeue succeeded) and the occupancy afterwards.
// A word accepted on the input is written into the command queue and, once the
// back end takes it, carried out on the slot array while loading the result register.
// Throughput: one word per cycle while the receiver does not stall; the slot array
// compares every slot in parallel to insert or remove an entry.
// Reset empties the queue and the two-word command queue.
// When the receiver stalls, the result register holds, the slot array stops,
// and the command queue takes up to two more words before item_stall rises.
// Depends on spq_pkg, spq_front and spq_back.
module sorted_priority_queue_core #(
	parameter int unsigned DEPTH          = spq_pkg::SPQ_DEPTH,
	parameter int unsigned VALUE_WIDTH    = spq_pkg::SPQ_VALUE_WIDTH,
	parameter int unsigned PRIORITY_WIDTH = spq_pkg::SPQ_PRIORITY_WIDTH,
	parameter int unsigned CNT_W          = $clog2(DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  logic                             kind,
	input  logic [VALUE_WIDTH-1:0]           item_value,
	input  logic signed [PRIORITY_WIDTH-1:0] item_priority,
	output logic                             result_valid,
	input  logic                             result_stall,
	output logic [1:0]                       status,
	output logic [VALUE_WIDTH-1:0]           out_value,
	output logic signed [PRIORITY_WIDTH-1:0] out_priority,
	output logic [CNT_W-1:0]                 occupancy
);
	import spq_pkg::*;

	cmd_ctl_t                         cmd_ctl;
	logic [VALUE_WIDTH-1:0]           cmd_value;
	logic signed [PRIORITY_WIDTH-1:0] cmd_priority;
	logic                             cmd_stall;

	// Accept and queue input words
	spq_front #(
		.VALUE_WIDTH    (VALUE_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.kind          (kind),
		.item_value    (item_value),
		.item_priority (item_priority),
		.cmd_ctl       (cmd_ctl),
		.cmd_value     (cmd_value),
		.cmd_priority  (cmd_priority),
		.cmd_stall     (cmd_stall)
	);

	// Carry out operations on the slot array
	spq_back #(
		.DEPTH          (DEPTH),
		.VALUE_WIDTH    (VALUE_WIDTH),
		.PRIORITY_WIDTH (PRIORITY_WIDTH),
		.CNT_W          (CNT_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_ctl      (cmd_ctl),
		.cmd_value    (cmd_value),
		.cmd_priority (cmd_priority),
		.cmd_stall    (cmd_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.out_value    (out_value),
		.out_priority (out_priority),
		.occupancy    (occupancy)
	);

endmodule
